FILE: rtl/core/pin_map_gamepad_encoder_core_assert.svh
// assertion macros for the pin map gamepad encoder core
`ifndef PIN_MAP_GAMEPAD_ENCODER_CORE_ASSERT_SVH
`define PIN_MAP_GAMEPAD_ENCODER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PMGE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pmge assertion failed");
`define PMGE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pmge assertion failed");
`else
`define PMGE_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define PMGE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/core/pmge_pkg.sv
// shared types, widths and function codes of the pin map gamepad encoder
`timescale 1ns / 1ps
package pmge_pkg;

    localparam int PMGE_PIN_COUNT = 20;
    localparam int PINS_W = 20;
    localparam int IDX_W  = 6;
    localparam int CODE_W = 8;
    localparam int BTN_W  = 13;
    localparam int HAT_W  = 4;
    localparam int AXIS_W = 8;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_SCAN  = 1'b1;

    localparam logic [AXIS_W-1:0] AXIS_MIN    = 8'h00;
    localparam logic [AXIS_W-1:0] AXIS_CENTER = 8'h80;
    localparam logic [AXIS_W-1:0] AXIS_MAX    = 8'hFF;

    localparam logic [HAT_W-1:0] HAT_UP         = 4'd0;
    localparam logic [HAT_W-1:0] HAT_UP_RIGHT   = 4'd1;
    localparam logic [HAT_W-1:0] HAT_RIGHT      = 4'd2;
    localparam logic [HAT_W-1:0] HAT_DOWN_RIGHT = 4'd3;
    localparam logic [HAT_W-1:0] HAT_DOWN       = 4'd4;
    localparam logic [HAT_W-1:0] HAT_DOWN_LEFT  = 4'd5;
    localparam logic [HAT_W-1:0] HAT_LEFT       = 4'd6;
    localparam logic [HAT_W-1:0] HAT_UP_LEFT    = 4'd7;
    localparam logic [HAT_W-1:0] HAT_CENTER     = 4'd8;

    // function codes held in the assignment store
    localparam logic [CODE_W-1:0] FN_HAT_UP     = 8'd1;
    localparam logic [CODE_W-1:0] FN_HAT_DOWN   = 8'd2;
    localparam logic [CODE_W-1:0] FN_HAT_LEFT   = 8'd3;
    localparam logic [CODE_W-1:0] FN_HAT_RIGHT  = 8'd4;
    localparam logic [CODE_W-1:0] FN_SQUARE     = 8'd5;
    localparam logic [CODE_W-1:0] FN_CROSS      = 8'd6;
    localparam logic [CODE_W-1:0] FN_CIRCLE     = 8'd7;
    localparam logic [CODE_W-1:0] FN_TRIANGLE   = 8'd8;
    localparam logic [CODE_W-1:0] FN_L1         = 8'd9;
    localparam logic [CODE_W-1:0] FN_R1         = 8'd10;
    localparam logic [CODE_W-1:0] FN_L2         = 8'd11;
    localparam logic [CODE_W-1:0] FN_R2         = 8'd12;
    localparam logic [CODE_W-1:0] FN_SELECT     = 8'd13;
    localparam logic [CODE_W-1:0] FN_START      = 8'd14;
    localparam logic [CODE_W-1:0] FN_L3         = 8'd15;
    localparam logic [CODE_W-1:0] FN_R3         = 8'd16;
    localparam logic [CODE_W-1:0] FN_PS         = 8'd17;
    localparam logic [CODE_W-1:0] FN_AN_UP      = 8'd18;
    localparam logic [CODE_W-1:0] FN_AN_DOWN    = 8'd19;
    localparam logic [CODE_W-1:0] FN_AN_LEFT    = 8'd20;
    localparam logic [CODE_W-1:0] FN_AN_RIGHT   = 8'd21;
    localparam logic [CODE_W-1:0] FN_RESTRICT   = 8'd22;
    localparam logic [CODE_W-1:0] FN_INVERT     = 8'd23;
    localparam logic [CODE_W-1:0] FN_AF_SQUARE  = 8'd24;
    localparam logic [CODE_W-1:0] FN_AF_CROSS   = 8'd25;
    localparam logic [CODE_W-1:0] FN_AF_CIRCLE  = 8'd26;
    localparam logic [CODE_W-1:0] FN_AF_TRIANGLE = 8'd27;
    localparam logic [CODE_W-1:0] FN_AF_MODE_LO = 8'd30;
    localparam logic [CODE_W-1:0] FN_AF_MODE_HI = 8'd38;
    localparam logic [CODE_W-1:0] FN_PROGRAM    = 8'd39;

    // button mask bit positions
    localparam int BIT_SQUARE   = 0;
    localparam int BIT_CROSS    = 1;
    localparam int BIT_CIRCLE   = 2;
    localparam int BIT_TRIANGLE = 3;
    localparam int BIT_L1       = 4;
    localparam int BIT_R1       = 5;
    localparam int BIT_L2       = 6;
    localparam int BIT_R2       = 7;
    localparam int BIT_L3       = 8;
    localparam int BIT_R3       = 9;
    localparam int BIT_SELECT   = 10;
    localparam int BIT_START    = 11;
    localparam int BIT_PS       = 12;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ1,
        ST_DRAIN1,
        ST_READ2,
        ST_DRAIN2,
        ST_EMIT
    } pmge_state_t;

endpackage

FILE: rtl/core/pmge_cmd_if.sv
// command channel: assignment writes and pin scans
`timescale 1ns / 1ps
interface pmge_cmd_if
    import pmge_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              op;
    logic [IDX_W-1:0]  entry_index;
    logic [CODE_W-1:0] entry_code;
    logic [PINS_W-1:0] pins_pressed;
    logic              shifted;

    modport source (output valid, op, entry_index, entry_code, pins_pressed, shifted,
                    input ready);
    modport sink (input valid, op, entry_index, entry_code, pins_pressed, shifted,
                  output ready);
endinterface

FILE: rtl/core/pmge_report_if.sv
// report channel: one gamepad report per scan
`timescale 1ns / 1ps
interface pmge_report_if
    import pmge_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [HAT_W-1:0]  hat_direction;
    logic [AXIS_W-1:0] x_axis;
    logic [AXIS_W-1:0] y_axis;
    logic [BTN_W-1:0]  button_mask;
    logic              bootloader_request;

    modport source (output valid, hat_direction, x_axis, y_axis, button_mask,
                    bootloader_request, input ready);
    modport sink (input valid, hat_direction, x_axis, y_axis, button_mask,
                  bootloader_request, output ready);
endinterface

FILE: rtl/core/pmge_store.sv
// assignment store: one write port, two registered read ports
`timescale 1ns / 1ps
module pmge_store
    import pmge_pkg::*;
#(
    parameter int DEPTH = 2 * PMGE_PIN_COUNT,
    parameter int AW    = $clog2(2 * PMGE_PIN_COUNT)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [CODE_W-1:0] wr_data,
    input  logic [AW-1:0]     rd_addr_a,
    input  logic [AW-1:0]     rd_addr_b,
    output logic [CODE_W-1:0] rd_data_a,
    output logic [CODE_W-1:0] rd_data_b
);

    logic [CODE_W-1:0] mem [DEPTH];
    logic [CODE_W-1:0] rd_a_reg;
    logic [CODE_W-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[rd_addr_b];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

FILE: rtl/core/pin_map_gamepad_encoder_core.sv
// top level of the pin map gamepad encoder: sequencer, pin decode and report register
// a write transfer is taken while idle and leaves the core ready at once
// a scan holds ready low through two passes over the store and the emit step, which waits
// for a free report register; the passes take one pin per cycle through the shared decode unit
// rst_n clears the sequencer, the report valid and sets the autofire phase to fire
`timescale 1ns / 1ps
`include "pin_map_gamepad_encoder_core_assert.svh"
module pin_map_gamepad_encoder_core
    import pmge_pkg::*;
#(
    parameter int PIN_COUNT = PMGE_PIN_COUNT
) (
    input  logic          clk,
    input  logic          rst_n,
    pmge_cmd_if.sink      cmd,
    pmge_report_if.source report
);

    // store geometry follows the pin count
    localparam int DEPTH = 2 * PIN_COUNT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;
    localparam logic [PW-1:0] LAST_PIN = PW'(PIN_COUNT - 1);
    localparam logic [IDX_W:0] DEPTH_IDX = (IDX_W + 1)'(DEPTH);

    // autofire codes: per-button autofire and the bare autofire modes
    function automatic logic is_autofire(input logic [CODE_W-1:0] code);
        is_autofire = ((code >= FN_AF_SQUARE) && (code <= FN_AF_TRIANGLE)) ||
                      ((code >= FN_AF_MODE_LO) && (code <= FN_AF_MODE_HI));
    endfunction

    // sequencer
    pmge_state_t state_reg, state_next;
    logic [PW-1:0] cnt_reg, cnt_next;

    // captured scan request
    logic [PINS_W-1:0] pins_reg;
    logic              shift_reg;

    // lag registers that line up a pin with its registered store data
    logic lag_vld_reg, lag_vld_next;
    logic lag_pass_reg;
    logic lag_pressed_reg;

    // pass-one flags
    logic inv_reg, inv_next;
    logic r4_reg, r4_next;
    logic af_reg, af_next;
    logic up_reg, up_next;
    logic dn_reg, dn_next;
    logic lf_reg, lf_next;
    logic rt_reg, rt_next;

    // pass-two accumulators
    logic [AXIS_W-1:0] x_reg, x_next;
    logic [AXIS_W-1:0] y_reg, y_next;
    logic [BTN_W-1:0]  btn_reg, btn_next;
    logic              boot_reg, boot_next;

    logic phase_reg, phase_next;

    // report register
    logic              out_vld_reg, out_vld_next;
    logic [HAT_W-1:0]  hat_out_reg;
    logic [AXIS_W-1:0] x_out_reg;
    logic [AXIS_W-1:0] y_out_reg;
    logic [BTN_W-1:0]  btn_out_reg;
    logic              boot_out_reg;

    // control outputs of the sequencer
    logic cmd_ready;
    logic issue_read;
    logic load_report;

    logic              cmd_xfer;
    logic              scan_start;
    logic              store_wr;
    logic [31:0]       pins_ext;
    logic              pin_pressed;
    logic [AW-1:0]     rd_addr_a;
    logic [AW-1:0]     rd_addr_b;
    logic [CODE_W-1:0] base_code;
    logic [CODE_W-1:0] act_code;
    logic [BTN_W-1:0]  btn_set;
    logic [BTN_W-1:0]  af_set;
    logic [HAT_W-1:0]  hat_value;
    logic              report_free;

    assign cmd_xfer   = cmd.valid && cmd_ready;
    assign scan_start = cmd_xfer && (cmd.op == OP_SCAN);
    // out-of-range write indexes are dropped
    assign store_wr   = cmd_xfer && (cmd.op == OP_WRITE) &&
                        ({1'b0, cmd.entry_index} < DEPTH_IDX);

    assign pins_ext    = 32'(pins_reg);
    assign pin_pressed = pins_ext[5'(cnt_reg)];

    // port a: unshifted entry, port b: active entry
    assign rd_addr_a = AW'(cnt_reg);
    assign rd_addr_b = shift_reg ? (AW'(cnt_reg) + AW'(PIN_COUNT)) : AW'(cnt_reg);

    pmge_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk       (clk),
        .wr_en     (store_wr),
        .wr_addr   (AW'(cmd.entry_index)),
        .wr_data   (cmd.entry_code),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (base_code),
        .rd_data_b (act_code)
    );

    assign report_free = !out_vld_reg || report.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (scan_start)
                begin
                    state_next = ST_READ1;
                end
            end
            ST_READ1:
            begin
                cnt_next = cnt_reg + PW'(1);
                if (cnt_reg == LAST_PIN)
                begin
                    state_next = ST_DRAIN1;
                    cnt_next   = '0;
                end
            end
            ST_DRAIN1:
            begin
                state_next = ST_READ2;
            end
            ST_READ2:
            begin
                cnt_next = cnt_reg + PW'(1);
                if (cnt_reg == LAST_PIN)
                begin
                    state_next = ST_DRAIN2;
                    cnt_next   = '0;
                end
            end
            ST_DRAIN2:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (report_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        cmd_ready   = 1'b0;
        issue_read  = 1'b0;
        load_report = 1'b0;
        unique case (state_reg)
            ST_IDLE:   cmd_ready   = 1'b1;
            ST_READ1:  issue_read  = 1'b1;
            ST_DRAIN1: issue_read  = 1'b0;
            ST_READ2:  issue_read  = 1'b1;
            ST_DRAIN2: issue_read  = 1'b0;
            ST_EMIT:   load_report = report_free;
            default:   cmd_ready   = 1'b0;
        endcase
    end

    assign lag_vld_next = issue_read;

    // button decode of the active code
    always_comb
    begin
        btn_set = '0;
        unique case (act_code)
            FN_SQUARE:   btn_set[BIT_SQUARE]   = 1'b1;
            FN_CROSS:    btn_set[BIT_CROSS]    = 1'b1;
            FN_CIRCLE:   btn_set[BIT_CIRCLE]   = 1'b1;
            FN_TRIANGLE: btn_set[BIT_TRIANGLE] = 1'b1;
            FN_L1:       btn_set[BIT_L1]       = 1'b1;
            FN_R1:       btn_set[BIT_R1]       = 1'b1;
            FN_L2:       btn_set[BIT_L2]       = 1'b1;
            FN_R2:       btn_set[BIT_R2]       = 1'b1;
            FN_L3:       btn_set[BIT_L3]       = 1'b1;
            FN_R3:       btn_set[BIT_R3]       = 1'b1;
            FN_SELECT:   btn_set[BIT_SELECT]   = 1'b1;
            FN_START:    btn_set[BIT_START]    = 1'b1;
            FN_PS:       btn_set[BIT_PS]       = 1'b1;
            default:     btn_set = '0;
        endcase
    end

    // autofire buttons, only while the phase is in its fire half
    always_comb
    begin
        af_set = '0;
        unique case (act_code)
            FN_AF_SQUARE:   af_set[BIT_SQUARE]   = 1'b1;
            FN_AF_CROSS:    af_set[BIT_CROSS]    = 1'b1;
            FN_AF_CIRCLE:   af_set[BIT_CIRCLE]   = 1'b1;
            FN_AF_TRIANGLE: af_set[BIT_TRIANGLE] = 1'b1;
            default:        af_set = '0;
        endcase
        if (!(af_reg && phase_reg))
        begin
            af_set = '0;
        end
    end

    // shared per-pin unit: pass one collects flags, pass two builds the report
    always_comb
    begin
        inv_next   = inv_reg;
        r4_next    = r4_reg;
        af_next    = af_reg;
        up_next    = up_reg;
        dn_next    = dn_reg;
        lf_next    = lf_reg;
        rt_next    = rt_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        btn_next   = btn_reg;
        boot_next  = boot_reg;
        phase_next = phase_reg;

        if (scan_start)
        begin
            inv_next  = 1'b0;
            r4_next   = 1'b0;
            af_next   = 1'b0;
            up_next   = 1'b0;
            dn_next   = 1'b0;
            lf_next   = 1'b0;
            rt_next   = 1'b0;
            x_next    = AXIS_CENTER;
            y_next    = AXIS_CENTER;
            btn_next  = '0;
            boot_next = 1'b0;
        end

        // phase flips once per scan with autofire held, before any button of pass two is decoded
        if ((state_reg == ST_READ2) && (cnt_reg == '0) && af_reg)
        begin
            phase_next = !phase_reg;
        end

        if (lag_vld_reg && lag_pressed_reg)
        begin
            if (!lag_pass_reg)
            begin
                // restrict and invert also trigger from the unshifted entry
                if ((base_code == FN_INVERT) || (act_code == FN_INVERT))
                begin
                    inv_next = 1'b1;
                end
                if ((base_code == FN_RESTRICT) || (act_code == FN_RESTRICT))
                begin
                    r4_next = 1'b1;
                end
                if (is_autofire(act_code))
                begin
                    af_next = 1'b1;
                end
                if (act_code == FN_HAT_UP)
                begin
                    up_next = 1'b1;
                end
                if (act_code == FN_HAT_DOWN)
                begin
                    dn_next = 1'b1;
                end
                if (act_code == FN_HAT_LEFT)
                begin
                    lf_next = 1'b1;
                end
                if (act_code == FN_HAT_RIGHT)
                begin
                    rt_next = 1'b1;
                end
            end
            else
            begin
                // later pins overwrite the axes, so the higher index wins
                btn_next = btn_reg | btn_set | af_set;
                if (act_code == (inv_reg ? FN_AN_DOWN : FN_AN_UP))
                begin
                    y_next = AXIS_MIN;
                end
                if (act_code == (inv_reg ? FN_AN_UP : FN_AN_DOWN))
                begin
                    y_next = AXIS_MAX;
                end
                if (act_code == FN_AN_LEFT)
                begin
                    x_next = AXIS_MIN;
                end
                if (act_code == FN_AN_RIGHT)
                begin
                    x_next = AXIS_MAX;
                end
                if (act_code == FN_PROGRAM)
                begin
                    boot_next = 1'b1;
                end
            end
        end
    end

    // hat from the pass-one direction flags
    always_comb
    begin
        hat_value = HAT_CENTER;
        if (r4_reg)
        begin
            // four-way: right beats left beats down beats up
            if (up_reg)
            begin
                hat_value = HAT_UP;
            end
            if (dn_reg)
            begin
                hat_value = HAT_DOWN;
            end
            if (lf_reg)
            begin
                hat_value = HAT_LEFT;
            end
            if (rt_reg)
            begin
                hat_value = HAT_RIGHT;
            end
        end
        else
        begin
            if (lf_reg)
            begin
                hat_value = HAT_LEFT;
            end
            if (rt_reg)
            begin
                hat_value = HAT_RIGHT;
            end
            if (up_reg)
            begin
                hat_value = lf_reg ? HAT_UP_LEFT : (rt_reg ? HAT_UP_RIGHT : HAT_UP);
            end
            if (dn_reg)
            begin
                hat_value = lf_reg ? HAT_DOWN_LEFT :
                            (rt_reg ? HAT_DOWN_RIGHT : HAT_DOWN);
            end
        end
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (load_report)
        begin
            out_vld_next = 1'b1;
        end
        else if (report.ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            lag_vld_reg <= 1'b0;
            phase_reg   <= 1'b1;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            lag_vld_reg <= lag_vld_next;
            phase_reg   <= phase_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (scan_start)
        begin
            pins_reg  <= cmd.pins_pressed;
            shift_reg <= cmd.shifted;
        end
        lag_pass_reg    <= (state_reg == ST_READ2);
        lag_pressed_reg <= pin_pressed;
        inv_reg  <= inv_next;
        r4_reg   <= r4_next;
        af_reg   <= af_next;
        up_reg   <= up_next;
        dn_reg   <= dn_next;
        lf_reg   <= lf_next;
        rt_reg   <= rt_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        btn_reg  <= btn_next;
        boot_reg <= boot_next;
        if (load_report)
        begin
            hat_out_reg  <= hat_value;
            x_out_reg    <= x_reg;
            y_out_reg    <= y_reg;
            btn_out_reg  <= btn_reg;
            boot_out_reg <= boot_reg;
        end
    end

    assign cmd.ready                 = cmd_ready;
    assign report.valid              = out_vld_reg;
    assign report.hat_direction      = hat_out_reg;
    assign report.x_axis             = x_out_reg;
    assign report.y_axis             = y_out_reg;
    assign report.button_mask        = btn_out_reg;
    assign report.bootloader_request = boot_out_reg;

    // a report appears only out of the emit step
    `PMGE_ASSERT_SAME(a_report_from_emit, clk, rst_n, $rose(out_vld_reg), $past(state_reg == ST_EMIT))
    // the autofire phase moves only at the start of pass two with autofire held
    `PMGE_ASSERT_SAME(a_phase_flip, clk, rst_n, phase_reg != $past(phase_reg), $past(state_reg == ST_READ2) && $past(af_reg))
    // a write transfer never starts the sequencer
    `PMGE_ASSERT_NEXT(a_write_stays_idle, clk, rst_n, cmd_xfer && (cmd.op == OP_WRITE), state_reg == ST_IDLE)

endmodule

FILE: test/tb.sv
// testbench for the pin map gamepad encoder core: directed and random scans against a predictor
`timescale 1ns / 1ps
module tb;
    import pmge_pkg::*;

    localparam int STORE_DEPTH      = 2 * PMGE_PIN_COUNT;
    // a scan needs two passes over the pins plus the drain and emit steps
    localparam int SCAN_CYCLES      = 2 * PMGE_PIN_COUNT + 3;
    localparam int LONG_HOLD_CYCLES = 300;
    // longest honest quiet spell is the long receiver hold plus one scan
    localparam int WATCHDOG_LIMIT   = 10 * (LONG_HOLD_CYCLES + SCAN_CYCLES);
    localparam int PIN_IDX_W        = $clog2(PINS_W);
    localparam int BTN_IDX_W        = $clog2(BTN_W);

    // one gamepad report as the predictor sees it
    typedef struct packed {
        logic [HAT_W-1:0]  hat;
        logic [AXIS_W-1:0] x_axis;
        logic [AXIS_W-1:0] y_axis;
        logic [BTN_W-1:0]  buttons;
        logic              boot;
    } gamepad_report_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    pmge_cmd_if    cmd ();
    pmge_report_if report ();

    pin_map_gamepad_encoder_core DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .report (report)
    );

    // predictor state: its own copy of the pin assignments and the autofire phase
    logic [CODE_W-1:0] pin_codes [STORE_DEPTH];
    logic              fire_phase;

    // reports owed by the core, oldest first
    gamepad_report_t   pending_reports [$];
    gamepad_report_t   next_report;

    int   error_count   = 0;
    int   idle_cycles   = 0;
    // random gaps on both channels while set
    logic idle_en       = 1'b1;
    // asks the report side to hold off for a long stretch
    logic long_hold_req = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor: one report per scan, written from the encoder rules
    // ------------------------------------------------------------------
    function automatic gamepad_report_t encode_scan(input logic [PINS_W-1:0] pins,
                                                    input logic shift);
        gamepad_report_t   r;
        logic              inv, r4, af, up, dn, lf, rt;
        logic [CODE_W-1:0] base, act;
        inv = 1'b0;
        r4  = 1'b0;
        af  = 1'b0;
        up  = 1'b0;
        dn  = 1'b0;
        lf  = 1'b0;
        rt  = 1'b0;
        r.hat     = HAT_CENTER;
        r.x_axis  = AXIS_CENTER;
        r.y_axis  = AXIS_CENTER;
        r.buttons = '0;
        r.boot    = 1'b0;

        // first pass: modifiers and hat directions
        for (int i = 0; i < PMGE_PIN_COUNT; i++)
        begin
            if (pins[i])
            begin
                base = pin_codes[i];
                act  = shift ? pin_codes[PMGE_PIN_COUNT + i] : base;
                // restrict and invert also work from the unshifted entry
                if (base == FN_INVERT || act == FN_INVERT)
                    inv = 1'b1;
                if (base == FN_RESTRICT || act == FN_RESTRICT)
                    r4 = 1'b1;
                if ((act >= FN_AF_SQUARE && act <= FN_AF_TRIANGLE) ||
                    (act >= FN_AF_MODE_LO && act <= FN_AF_MODE_HI))
                    af = 1'b1;
                if (act == FN_HAT_UP)
                    up = 1'b1;
                if (act == FN_HAT_DOWN)
                    dn = 1'b1;
                if (act == FN_HAT_LEFT)
                    lf = 1'b1;
                if (act == FN_HAT_RIGHT)
                    rt = 1'b1;
            end
        end

        // the phase flips before the autofire buttons look at it
        if (af)
            fire_phase = ~fire_phase;

        if (r4)
        begin
            // four-way: last of up, down, left, right wins
            if (up)
                r.hat = HAT_UP;
            if (dn)
                r.hat = HAT_DOWN;
            if (lf)
                r.hat = HAT_LEFT;
            if (rt)
                r.hat = HAT_RIGHT;
        end
        else
        begin
            if (lf)
                r.hat = HAT_LEFT;
            if (rt)
                r.hat = HAT_RIGHT;
            if (up)
                r.hat = lf ? HAT_UP_LEFT : (rt ? HAT_UP_RIGHT : HAT_UP);
            // down overrides up
            if (dn)
                r.hat = lf ? HAT_DOWN_LEFT : (rt ? HAT_DOWN_RIGHT : HAT_DOWN);
        end

        // second pass: buttons, analog axes and program mode, higher pin wins
        for (int i = 0; i < PMGE_PIN_COUNT; i++)
        begin
            if (pins[i])
            begin
                act = pin_codes[shift ? PMGE_PIN_COUNT + i : i];
                if (act >= FN_SQUARE && act <= FN_TRIANGLE)
                    r.buttons[BTN_IDX_W'(BIT_SQUARE + int'(act - FN_SQUARE))] = 1'b1;
                if (af && fire_phase && act >= FN_AF_SQUARE && act <= FN_AF_TRIANGLE)
                    r.buttons[BTN_IDX_W'(BIT_SQUARE + int'(act - FN_AF_SQUARE))] = 1'b1;
                if (act >= FN_L1 && act <= FN_R2)
                    r.buttons[BTN_IDX_W'(BIT_L1 + int'(act - FN_L1))] = 1'b1;
                if (act == FN_L3)
                    r.buttons[BIT_L3] = 1'b1;
                if (act == FN_R3)
                    r.buttons[BIT_R3] = 1'b1;
                if (act == FN_SELECT)
                    r.buttons[BIT_SELECT] = 1'b1;
                if (act == FN_START)
                    r.buttons[BIT_START] = 1'b1;
                if (act == FN_PS)
                    r.buttons[BIT_PS] = 1'b1;
                if (act == (inv ? FN_AN_DOWN : FN_AN_UP))
                    r.y_axis = AXIS_MIN;
                if (act == (inv ? FN_AN_UP : FN_AN_DOWN))
                    r.y_axis = AXIS_MAX;
                if (act == FN_AN_LEFT)
                    r.x_axis = AXIS_MIN;
                if (act == FN_AN_RIGHT)
                    r.x_axis = AXIS_MAX;
                if (act == FN_PROGRAM)
                    r.boot = 1'b1;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // command side: one transfer, with an optional random gap in front
    // called and left at a falling edge
    // ------------------------------------------------------------------
    task automatic send_cmd(input logic op, input logic [IDX_W-1:0] idx,
                            input logic [CODE_W-1:0] code, input logic [PINS_W-1:0] pins,
                            input logic shift);
        if (idle_en && $urandom_range(0, 4) == 0)
        begin
            cmd.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        cmd.valid        <= 1'b1;
        cmd.op           <= op;
        cmd.entry_index  <= idx;
        cmd.entry_code   <= code;
        cmd.pins_pressed <= pins;
        cmd.shifted      <= shift;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        // transfer taken: update the predictor in acceptance order
        if (op == OP_WRITE)
        begin
            // indexes past the store are dropped
            if (idx < STORE_DEPTH)
                pin_codes[idx] = code;
        end
        else
            pending_reports.push_back(encode_scan(pins, shift));
        @(negedge clk);
    endtask

    // unused fields of each kind carry random values
    task automatic write_entry(input logic [IDX_W-1:0] idx, input logic [CODE_W-1:0] code);
        send_cmd(OP_WRITE, idx, code, PINS_W'($urandom()), 1'($urandom_range(0, 1)));
    endtask

    task automatic scan_pins(input logic [PINS_W-1:0] pins, input logic shift);
        send_cmd(OP_SCAN, IDX_W'($urandom()), CODE_W'($urandom()), pins, shift);
    endtask

    // mostly meaningful codes, now and then anything up to 0xFF
    function automatic logic [CODE_W-1:0] pick_code();
        if ($urandom_range(0, 9) == 0)
            return CODE_W'($urandom_range(0, 255));
        return CODE_W'($urandom_range(0, 40));
    endfunction

    // sparse masks keep single functions visible, full masks stress priority
    function automatic logic [PINS_W-1:0] pick_pins();
        logic [PINS_W-1:0] p;
        p = '0;
        if ($urandom_range(0, 3) == 0)
            p = PINS_W'($urandom());
        else
            repeat ($urandom_range(0, 4))
                p[PIN_IDX_W'($urandom_range(0, PINS_W - 1))] = 1'b1;
        return p;
    endfunction

    // ------------------------------------------------------------------
    // report side: random stalls, and the long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        report.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                report.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
                long_hold_req = 1'b0;
            end
            else if (idle_en && $urandom_range(0, 5) == 0)
            begin
                report.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge clk);
            end
            else
                report.ready <= 1'b1;
        end
    end

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            error_count++;
        end
    endtask

    // every report transfer is matched against the oldest owed report
    always @(posedge clk)
    begin
        if (rst_n && report.valid && report.ready)
        begin
            if (pending_reports.size() == 0)
            begin
                $display("%0t: report with none expected, expected nothing, actual hat %0d",
                         $time, report.hat_direction);
                error_count++;
            end
            else
            begin
                next_report = pending_reports.pop_front();
                check_field("hat_direction", 16'(next_report.hat),
                            16'(report.hat_direction));
                check_field("x_axis", 16'(next_report.x_axis), 16'(report.x_axis));
                check_field("y_axis", 16'(next_report.y_axis), 16'(report.y_axis));
                check_field("button_mask", 16'(next_report.buttons),
                            16'(report.button_mask));
                check_field("bootloader_request", 16'(next_report.boot),
                            16'(report.bootloader_request));
            end
        end
    end

    // watchdog: too long without any transfer on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (cmd.valid && cmd.ready) || (report.valid && report.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------
    // test tasks
    // ------------------------------------------------------------------

    // hat decode on pins 0..4, eight-way and four-way
    task automatic test_hat_directions();
        write_entry(0, FN_HAT_UP);
        write_entry(1, FN_HAT_DOWN);
        write_entry(2, FN_HAT_LEFT);
        write_entry(3, FN_HAT_RIGHT);
        write_entry(4, FN_RESTRICT);
        scan_pins(20'h00000, 1'b0);   // nothing pressed: center
        scan_pins(20'h00005, 1'b0);   // up and left
        scan_pins(20'h0000A, 1'b0);   // down and right
        scan_pins(20'h0000B, 1'b0);   // down overrides up
        scan_pins(20'h0000C, 1'b0);   // left and right: right wins
        scan_pins(20'h00013, 1'b0);   // four-way: down last
        scan_pins(20'h0001F, 1'b0);   // four-way: right last
    endtask

    // shifted entries: analog axes, invert, program mode, autofire, unknown code
    task automatic test_shifted_functions();
        write_entry(5, FN_INVERT);
        write_entry(IDX_W'(PMGE_PIN_COUNT + 0), FN_AN_LEFT);
        write_entry(IDX_W'(PMGE_PIN_COUNT + 1), FN_AN_RIGHT);
        write_entry(IDX_W'(PMGE_PIN_COUNT + 2), FN_AN_UP);
        write_entry(IDX_W'(PMGE_PIN_COUNT + 3), FN_AN_DOWN);
        write_entry(IDX_W'(PMGE_PIN_COUNT + 4), FN_PROGRAM);
        write_entry(IDX_W'(PMGE_PIN_COUNT + 5), FN_AF_SQUARE);
        // top pin: unknown code unshifted, autofire mode shifted
        write_entry(IDX_W'(PMGE_PIN_COUNT - 1), 8'hFF);
        write_entry(IDX_W'(STORE_DEPTH - 1), FN_AF_MODE_HI);
        // write past the end of the store must be dropped
        write_entry(6'h3F, FN_PROGRAM);
        scan_pins(20'h0000C, 1'b1);   // analog up then down
        scan_pins(20'h0002C, 1'b1);   // same under invert held via the base entry
        scan_pins(20'h00023, 1'b1);   // x left then right, autofire square
        scan_pins(20'h00020, 1'b1);   // autofire again: phase flips back
        scan_pins(20'h80010, 1'b1);   // program mode, restrict from base, autofire mode
        scan_pins(20'h80000, 1'b0);   // unknown code does nothing
    endtask

    // whole store gets random codes, so later random scans never hit a blank entry
    task automatic test_random_fill();
        for (int i = 0; i < STORE_DEPTH; i++)
            write_entry(IDX_W'(i), pick_code());
    endtask

    // mixed writes and scans with random content
    task automatic test_random_traffic(input int count);
        repeat (count)
        begin
            if ($urandom_range(0, 4) == 0)
                write_entry(IDX_W'(($urandom_range(0, 9) == 0)
                                   ? $urandom_range(STORE_DEPTH, 63)
                                   : $urandom_range(0, STORE_DEPTH - 1)),
                            pick_code());
            else
                scan_pins(pick_pins(), 1'($urandom_range(0, 1)));
        end
    endtask

    // report side holds off while scans keep coming, so the core stalls its input
    task automatic test_report_backpressure();
        long_hold_req = 1'b1;
        repeat (10) scan_pins(pick_pins(), 1'($urandom_range(0, 1)));
    endtask

    // last stretch with no gaps on either side
    task automatic test_back_to_back();
        idle_en = 1'b0;
        test_random_traffic(60);
    endtask

    initial
    begin
        cmd.valid        = 1'b0;
        cmd.op           = OP_WRITE;
        cmd.entry_index  = '0;
        cmd.entry_code   = '0;
        cmd.pins_pressed = '0;
        cmd.shifted      = 1'b0;
        fire_phase       = 1'b1;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_hat_directions();
        test_shifted_functions();
        test_random_fill();
        test_random_traffic(420);
        test_report_backpressure();
        test_back_to_back();
        cmd.valid <= 1'b0;

        // drain owed reports, then give a stray report time to show up
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SCAN_CYCLES + 10) @(posedge clk);

        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
